### src/jsu_pkg.sv
package jsu_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [1:0] ERR_UNTERM = 2'd0;
  localparam logic [1:0] ERR_ESC    = 2'd1;
  localparam logic [1:0] ERR_UNI    = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [20:0] CP_REPL = 21'h00FFFD;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] err;
  } item_t;

  // one accepted byte: optional code point first, then up to two single items
  typedef struct packed {
    logic        cp_v;
    logic [20:0] cp;
    logic        s0_v;
    item_t       s0;
    logic        s1_v;
    item_t       s1;
  } cmd_t;

endpackage

### src/jsu_front.sv
module jsu_front import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_STR     = 7'b0000010,
    M_ESC     = 7'b0000100,
    M_HEX     = 7'b0001000,
    M_HIGH    = 7'b0010000,
    M_HIGH_BS = 7'b0100000,
    M_LOW     = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    mode_e mode;
    logic  v;
    item_t item;
  } step_t;

  function automatic item_t mk_item(logic [1:0] kind, logic [7:0] data, logic [1:0] err);
    item_t it;
    it.kind = kind;
    it.data = data;
    it.err  = err;
    return it;
  endfunction

  function automatic cmd_t add_item(cmd_t c, item_t it);
    cmd_t r;
    r = c;
    if (!r.s0_v) begin
      r.s0_v = 1'b1;
      r.s0   = it;
    end else begin
      r.s1_v = 1'b1;
      r.s1   = it;
    end
    return r;
  endfunction

  function automatic hex_t hex_val(logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic step_t str_step(logic [7:0] b);
    step_t s;
    s.mode = M_STR;
    s.v    = 1'b1;
    s.item = mk_item(KIND_DATA, b, 2'd0);
    if (b == CH_QUOTE) begin
      s.mode = M_IDLE;
      s.item = mk_item(KIND_CLOSE, 8'd0, 2'd0);
    end else if (b == CH_BSL) begin
      s.mode = M_ESC;
      s.v    = 1'b0;
    end
    return s;
  endfunction

  function automatic step_t esc_step(logic [7:0] b);
    step_t s;
    s.mode = M_STR;
    s.v    = 1'b1;
    s.item = mk_item(KIND_DATA, b, 2'd0);
    case (b) inside
      CH_QUOTE, CH_BSL, CH_SLASH: s.item.data = b;
      CH_B: s.item.data = 8'h08;
      CH_F: s.item.data = 8'h0C;
      CH_N: s.item.data = 8'h0A;
      CH_R: s.item.data = 8'h0D;
      CH_T: s.item.data = 8'h09;
      CH_U: begin
        s.mode = M_HEX;
        s.v    = 1'b0;
      end
      default: begin
        s.mode = M_IDLE;
        s.item = mk_item(KIND_ERR, 8'd0, ERR_ESC);
      end
    endcase
    return s;
  endfunction

  mode_e       mode_q, mode_d;
  logic [1:0]  hc_q, hc_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] hh_q, hh_d;
  hex_t        hv;
  logic [15:0] acc_n;
  step_t       sr, er;
  cmd_t        cmd;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && (cmd.cp_v || cmd.s0_v);
  assign cmd_o      = cmd;

  always_comb begin
    mode_d = mode_q;
    hc_d   = hc_q;
    acc_d  = acc_q;
    hh_d   = hh_q;
    cmd    = '0;
    hv     = hex_val(text_byte_i);
    acc_n  = {acc_q[11:0], hv.val};
    sr     = str_step(text_byte_i);
    er     = esc_step(text_byte_i);
    unique case (mode_q)
      M_STR: begin
        mode_d = sr.mode;
        if (sr.v) cmd = add_item(cmd, sr.item);
      end
      M_ESC: begin
        mode_d = er.mode;
        if (er.v) cmd = add_item(cmd, er.item);
        if (er.mode == M_HEX) begin
          hc_d  = 2'd0;
          acc_d = 16'd0;
        end
      end
      M_HEX: begin
        if (!hv.ok) begin
          cmd    = add_item(cmd, mk_item(KIND_ERR, 8'd0, ERR_UNI));
          mode_d = M_IDLE;
        end else begin
          acc_d = acc_n;
          if (hc_q == 2'd3) begin
            hc_d = 2'd0;
            if (acc_n[15:10] == 6'b110110) begin
              hh_d   = acc_n;
              mode_d = M_HIGH;
            end else begin
              mode_d   = M_STR;
              cmd.cp_v = 1'b1;
              cmd.cp   = (acc_n[15:10] == 6'b110111) ? CP_REPL : {5'd0, acc_n};
            end
          end else begin
            hc_d = hc_q + 2'd1;
          end
        end
      end
      M_HIGH: begin
        if (text_byte_i == CH_BSL) begin
          mode_d = M_HIGH_BS;
        end else begin
          cmd.cp_v = 1'b1;
          cmd.cp   = CP_REPL;
          mode_d   = sr.mode;
          if (sr.v) cmd = add_item(cmd, sr.item);
        end
      end
      M_HIGH_BS: begin
        if (text_byte_i == CH_U) begin
          mode_d = M_LOW;
          hc_d   = 2'd0;
          acc_d  = 16'd0;
        end else begin
          cmd.cp_v = 1'b1;
          cmd.cp   = CP_REPL;
          mode_d   = er.mode;
          if (er.v) cmd = add_item(cmd, er.item);
        end
      end
      M_LOW: begin
        if (!hv.ok) begin
          cmd.cp_v = 1'b1;
          cmd.cp   = CP_REPL;
          cmd      = add_item(cmd, mk_item(KIND_ERR, 8'd0, ERR_UNI));
          mode_d   = M_IDLE;
        end else begin
          acc_d = acc_n;
          if ((hc_q == 2'd0 && hv.val != 4'hD) || (hc_q == 2'd1 && hv.val < 4'hC)) begin
            cmd.cp_v = 1'b1;
            cmd.cp   = CP_REPL;
            mode_d   = M_HEX;
            hc_d     = hc_q + 2'd1;
          end else if (hc_q == 2'd3) begin
            cmd.cp_v = 1'b1;
            cmd.cp   = 21'h010000 + {1'b0, hh_q[9:0], acc_n[9:0]};
            mode_d   = M_STR;
            hc_d     = 2'd0;
          end else begin
            hc_d = hc_q + 2'd1;
          end
        end
      end
      default: begin
        mode_d = (text_byte_i == CH_QUOTE) ? M_STR : M_IDLE;
      end
    endcase
    if (end_of_text_i) begin
      unique case (mode_d)
        M_STR, M_ESC: cmd = add_item(cmd, mk_item(KIND_ERR, 8'd0, ERR_UNTERM));
        M_HEX: cmd = add_item(cmd, mk_item(KIND_ERR, 8'd0, ERR_UNI));
        M_HIGH, M_HIGH_BS: begin
          cmd.cp_v = 1'b1;
          cmd.cp   = CP_REPL;
          cmd      = add_item(cmd, mk_item(KIND_ERR, 8'd0, ERR_UNTERM));
        end
        M_LOW: begin
          cmd.cp_v = 1'b1;
          cmd.cp   = CP_REPL;
          cmd      = add_item(cmd, mk_item(KIND_ERR, 8'd0, ERR_UNI));
        end
        default: ;
      endcase
      mode_d = M_IDLE;
      hc_d   = 2'd0;
      acc_d  = 16'd0;
      hh_d   = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hc_q   <= 2'd0;
      acc_q  <= 16'd0;
      hh_q   <= 16'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      hc_q   <= hc_d;
      acc_q  <= acc_d;
      hh_q   <= hh_d;
    end
  end

endmodule

### src/jsu_queue.sv
module jsu_queue import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t             mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == QCW'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= QAW'(wr_q + 1'b1);
      if (do_pop) rd_q <= QAW'(rd_q + 1'b1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/jsu_back.sv
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] error_code_o,
  output logic       last_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  function automatic logic [2:0] cp_len(logic [20:0] cp);
    if (cp < 21'h80) return 3'd1;
    else if (cp < 21'h800) return 3'd2;
    else if (cp < 21'h10000) return 3'd3;
    else return 3'd4;
  endfunction

  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] n, logic [2:0] k);
    logic [7:0] b;
    b = 8'h80 | {2'b00, cp[5:0]};
    case (n)
      3'd1: b = cp[7:0];
      3'd2: if (k == 3'd0) b = 8'hC0 | {3'b000, cp[10:6]};
      3'd3: begin
        if (k == 3'd0) b = 8'hE0 | {4'b0000, cp[15:12]};
        else if (k == 3'd1) b = 8'h80 | {2'b00, cp[11:6]};
      end
      default: begin
        if (k == 3'd0) b = 8'hF0 | {5'b00000, cp[20:18]};
        else if (k == 3'd1) b = 8'h80 | {2'b00, cp[17:12]};
        else if (k == 3'd2) b = 8'h80 | {2'b00, cp[11:6]};
      end
    endcase
    return b;
  endfunction

  logic [2:0] idx_q;
  logic [2:0] ncp, total, j;
  logic       load, is_last;
  item_t      cur;
  logic       out_valid_q;
  item_t      out_q;
  logic       last_q;

  always_comb begin
    ncp   = head_i.cp_v ? cp_len(head_i.cp) : 3'd0;
    total = ncp + {2'b00, head_i.s0_v} + {2'b00, head_i.s1_v};
    j     = idx_q - ncp;
    if (idx_q < ncp) begin
      cur.kind = KIND_DATA;
      cur.data = utf8_byte(head_i.cp, ncp, idx_q);
      cur.err  = 2'd0;
    end else if (j == 3'd0) begin
      cur = head_i.s0;
    end else begin
      cur = head_i.s1;
    end
  end

  assign is_last = (idx_q == total - 3'd1);
  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= cur;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign data_byte_o  = out_q.data;
  assign error_code_o = out_q.err;
  assign last_o       = last_q;

endmodule

### src/json_string_unescape_utf8_top.sv
// channel | handshake              | payload
// --------+------------------------+-----------------------------------------
// in      | in_valid_i, in_ready_o | text_byte_i, end_of_text_i
// out     | out_valid_o, out_ready_i | kind_o, data_byte_o, error_code_o, last_o
//
// one input item per cycle while the 4-entry command queue has room
// each item yields 0 to 5 result items; the back end sends one per cycle
// while out_ready_i is high
// an accepted input item is registered in the command queue, then its results in the output register
// rst_ni clears parser state, queue pointers and output valid; no clearing pass
// a stall on out_ready_i fills the queue, then drops in_ready_o
module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] error_code_o,
  output logic       last_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  logic q_full, push, pop, head_valid;
  cmd_t cmd, head;

  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  jsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .error_code_o (error_code_o),
    .last_o       (last_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule
